FILE: design/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

   // Fixed field widths of the stream and configuration ports.
   localparam int CHAR_W      = 8;
   localparam int IDX_W       = 11;
   localparam int CELL_W      = 16;
   localparam int POS_W       = 11;
   localparam int COLOR_W     = 4;
   localparam int OP_W        = 1;
   localparam int CSR_ADDR_W  = 1;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // Operation codes carried on req_tuser.
   localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
   localparam logic [OP_W-1:0] OP_READ = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_FG = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_BG = 1'b1;

   // Character codes with special meaning.
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_BLANK,
      ST_FINISH
   } ctrl_state_type;

   // Source of the screen memory write port.
   typedef enum logic [2:0] {
      WR_NONE,
      WR_INIT,
      WR_CHAR,
      WR_COPY,
      WR_BLANK
   } wr_sel_type;

   // Source of the screen memory read address.
   typedef enum logic {
      RD_INDEX,
      RD_COPY
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       exec_put;
      logic       load_rsp;
      logic       cnt_clr;
      logic       cnt_inc;
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_read;
      logic scroll;
      logic copy_done;
      logic cnt_last;
   } dp_status_type;

endpackage

FILE: design/tccw_datapath.sv
`timescale 1ns / 1ps

module tccw_datapath import tccw_pkg::*; #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25,
   parameter int TAB_STOP      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [IDX_W-1:0]      req_read_index,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [COLOR_W-1:0]    csr_wdata,
   output logic [CELL_W-1:0]     rsp_cell_data,
   output logic [POS_W-1:0]      rsp_cursor_pos
);

   localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(SCREEN_WIDTH);
   localparam int COLX_W = $clog2(SCREEN_WIDTH + TAB_STOP + 1);
   localparam int PH_W   = $clog2(TAB_STOP);
   localparam int COPY_N = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
   localparam int CMP_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

   // Latched request.
   logic [OP_W-1:0]   op_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [IDX_W-1:0]  idx_ff;

   // Cursor: column, start address of the cursor row, column modulo the tab stop.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [PH_W-1:0]   phase_ff, phase_in;

   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;

   // Sweep counter for the clearing pass, the scroll copy and the bottom-row blanking.
   logic [ADDR_W-1:0] cnt_ff, cnt_in;

   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   // Screen memory and its registered read data.
   logic [CELL_W-1:0] screen_mem [CELLS];
   logic [CELL_W-1:0] rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   logic [COLX_W-1:0] col_nx;
   logic [PH_W-1:0]   phase_nx;
   logic              is_bs;
   logic              is_print;
   logic              is_lf;
   logic              wrap;
   logic              last_row;
   logic              in_range;
   logic [ADDR_W-1:0] cursor_addr;

   // Decode the put character and work out the cursor move.
   always_comb begin
      is_bs    = (ch_ff == CH_BACKSPACE) && (col_ff != '0);
      is_lf    = (ch_ff == CH_LF);
      is_print = 1'b0;
      col_nx   = '0;
      phase_nx = '0;
      if (is_bs) begin
         col_nx   = COLX_W'(col_ff) - COLX_W'(1);
         phase_nx = (phase_ff == '0) ? PH_W'(TAB_STOP - 1) : phase_ff - PH_W'(1);
      end else if (ch_ff == CH_TAB) begin
         col_nx = COLX_W'(col_ff) + COLX_W'(TAB_STOP) - COLX_W'(phase_ff);
      end else if ((ch_ff == CH_CR) || is_lf) begin
         col_nx = '0;
      end else begin
         is_print = 1'b1;
         col_nx   = COLX_W'(col_ff) + COLX_W'(1);
         phase_nx = (phase_ff == PH_W'(TAB_STOP - 1)) ? '0 : phase_ff + PH_W'(1);
      end
      wrap        = is_lf || (col_nx >= COLX_W'(SCREEN_WIDTH));
      last_row    = (base_ff == ADDR_W'(COPY_N));
      cursor_addr = base_ff + ADDR_W'(col_ff);
      in_range    = CMP_W'(idx_ff) < CMP_W'(CELLS);
   end

   // Cursor and color updates.
   always_comb begin
      col_in   = col_ff;
      base_in  = base_ff;
      phase_in = phase_ff;
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      if (cmd.exec_put) begin
         if (wrap) begin
            col_in   = '0;
            phase_in = '0;
            // On the bottom row a scroll keeps the cursor on the same row.
            if (!last_row) begin
               base_in = base_ff + ADDR_W'(SCREEN_WIDTH);
            end
         end else begin
            col_in   = col_nx[COL_W-1:0];
            phase_in = phase_nx;
         end
      end
      if (csr_we) begin
         case (csr_addr)
            REG_FG: fg_in = csr_wdata;
            REG_BG: bg_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sweep counter.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + ADDR_W'(1);
      end
   end

   // Memory port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = {fg_ff, bg_ff, CH_SPACE};
      case (cmd.wr_sel)
         WR_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = CELL_W'(CH_SPACE);
         end
         WR_CHAR: begin
            mem_we    = cmd.exec_put && is_print;
            mem_waddr = cursor_addr;
            mem_wdata = {fg_ff, bg_ff, ch_ff};
         end
         WR_COPY: begin
            // The cell read in the previous cycle lands one row higher.
            mem_we    = (cnt_ff != '0);
            mem_waddr = cnt_ff - ADDR_W'(1);
            mem_wdata = rdata_ff;
         end
         WR_BLANK: begin
            mem_we = 1'b1;
         end
         default: begin
         end
      endcase
      case (cmd.rd_sel)
         RD_COPY: mem_raddr = cnt_ff + ADDR_W'(SCREEN_WIDTH);
         default: mem_raddr = ADDR_W'(idx_ff);
      endcase
   end

   // Result values.
   always_comb begin
      cell_in = cell_ff;
      pos_in  = pos_ff;
      if (cmd.load_rsp) begin
         cell_in = ((op_ff == OP_READ) && in_range) ? rdata_ff : '0;
         pos_in  = POS_W'(cursor_addr);
      end
   end

   // Screen memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= screen_mem[mem_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         base_ff  <= '0;
         phase_ff <= '0;
         fg_ff    <= '0;
         bg_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         col_ff   <= col_in;
         base_ff  <= base_in;
         phase_ff <= phase_in;
         fg_ff    <= fg_in;
         bg_ff    <= bg_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_operation;
         ch_ff  <= req_char_code;
         idx_ff <= req_read_index;
      end
      cell_ff <= cell_in;
      pos_ff  <= pos_in;
   end

   assign status.op_read   = (op_ff == OP_READ);
   assign status.scroll    = wrap && last_row;
   assign status.copy_done = (cnt_ff == ADDR_W'(COPY_N));
   assign status.cnt_last  = (cnt_ff == ADDR_W'(CELLS - 1));

   assign rsp_cell_data  = cell_ff;
   assign rsp_cursor_pos = pos_ff;

endmodule

FILE: design/tccw_ctrl.sv
`timescale 1ns / 1ps

module tccw_ctrl import tccw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!status.op_read && status.scroll) state_in = ST_COPY;
            else state_in = ST_FINISH;
         end
         ST_COPY: begin
            if (status.copy_done) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (status.cnt_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // The output slot empties on a taken transaction and fills on a finished item.
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      cmd.wr_sel = WR_NONE;
      cmd.rd_sel = RD_INDEX;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_sel  = WR_INIT;
            cmd.cnt_inc = !status.cnt_last;
         end
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_EXEC: begin
            if (!status.op_read) begin
               cmd.exec_put = 1'b1;
               cmd.wr_sel   = WR_CHAR;
               cmd.cnt_clr  = status.scroll;
            end
         end
         ST_COPY: begin
            cmd.wr_sel = WR_COPY;
            if (!status.copy_done) begin
               cmd.rd_sel  = RD_COPY;
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_BLANK: begin
            cmd.wr_sel  = WR_BLANK;
            cmd.cnt_inc = !status.cnt_last;
         end
         ST_FINISH: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: design/text_console_cell_writer.sv
`timescale 1ns / 1ps

// Text console cell writer: a SCREEN_WIDTH x SCREEN_HEIGHT screen of 16-bit cells
// (character in bits 7:0, background in 11:8, foreground in 15:12) with a cursor.
// A put transaction interprets tab, carriage return, line feed and backspace
// off column zero, and writes every other byte at the cursor; a read transaction
// returns one cell, or zero for an index beyond the screen. Each item gives one
// result with the cell (zero for a put) and the linear cursor position after the
// item. After reset the block fills the screen memory with spaces and accepts no
// item meanwhile; configuration writes are taken at any time. An ordinary item
// is latched on acceptance, then the memory access and cursor update take place,
// then the result is loaded into the output register once that register is free.
// A put that scrolls first moves every row below the top up by one through the
// memory's one read and one write port, then blanks the bottom row in the current
// colors. The next item may be accepted while a result still waits on the output.
module text_console_cell_writer import tccw_pkg::*; #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25,
   parameter int TAB_STOP      = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [OP_W-1:0]        req_tuser,   // operation
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // char_code, read_index, zero fill
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // cell_data, cursor_pos, zero fill
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [COLOR_W-1:0]     csr_wdata
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [CELL_W-1:0]  cell_data;
   logic [POS_W-1:0]   cursor_pos;

   tccw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tccw_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_STOP      (TAB_STOP)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_tuser),
      .req_char_code  (req_tdata[CHAR_W-1:0]),
      .req_read_index (req_tdata[CHAR_W+IDX_W-1:CHAR_W]),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .rsp_cell_data  (cell_data),
      .rsp_cursor_pos (cursor_pos)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {(RSP_TDATA_W - CELL_W - POS_W)'(0), cursor_pos, cell_data};

endmodule

FILE: design/tccw_checker.sv
`timescale 1ns / 1ps

module tccw_checker import tccw_pkg::*; #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CellCount = SCREEN_WIDTH * SCREEN_HEIGHT;

   // Reset starts the clearing pass with an empty output slot.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("ready or result valid right after reset");

   // One item at a time: the input closes after each accepted transaction.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after an accepted transaction");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // The reported cursor always lies on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[CELL_W +: POS_W]) < CellCount)
      else $error("cursor position beyond the screen");

endmodule

bind text_console_cell_writer tccw_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tccw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tccw_pkg::*;

   localparam int SCREEN_W   = 80;
   localparam int SCREEN_H   = 25;
   localparam int TAB_W      = 8;
   localparam int CELLS      = SCREEN_W * SCREEN_H;
   localparam int LONG_HOLD  = 400;
   localparam int PHASE_ITEMS = 246;

   // Expected contents of one response transaction.
   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [POS_W-1:0]  pos;
   } screen_reply_t;

   // Mirror of the screen, cursor and colors; predicts each response.
   class screen_mirror;
      logic [CELL_W-1:0] screen [CELLS];
      int unsigned       col;
      int unsigned       row;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      screen_reply_t     pending_replies[$];
      int                failures;

      function new();
         foreach (screen[i]) screen[i] = {8'h00, CH_SPACE};
         col = 0;
         row = 0;
         fg = '0;
         bg = '0;
         failures = 0;
      endfunction

      function void set_color(logic [CSR_ADDR_W-1:0] addr, logic [COLOR_W-1:0] value);
         if (addr == REG_FG) fg = value;
         else if (addr == REG_BG) bg = value;
      endfunction

      function int unsigned cursor();
         return row * SCREEN_W + col;
      endfunction

      function int outstanding();
         return pending_replies.size();
      endfunction

      // Interpret one character and move the cursor, scrolling when it falls off the bottom.
      function void apply_put(logic [CHAR_W-1:0] ch);
         if (ch == CH_BACKSPACE && col != 0) begin
            col--;
         end else if (ch == CH_TAB) begin
            col = col + TAB_W - (col % TAB_W);
         end else if (ch == CH_CR) begin
            col = 0;
         end else if (ch == CH_LF) begin
            col = 0;
            row++;
         end else begin
            screen[row * SCREEN_W + col] = {fg, bg, ch};
            col++;
         end
         if (col >= SCREEN_W) begin
            col = 0;
            row++;
         end
         if (row >= SCREEN_H) begin
            for (int i = 0; i < (SCREEN_H - 1) * SCREEN_W; i++) screen[i] = screen[i + SCREEN_W];
            for (int i = (SCREEN_H - 1) * SCREEN_W; i < CELLS; i++) screen[i] = {fg, bg, CH_SPACE};
            row = SCREEN_H - 1;
         end
      endfunction

      // Called for every accepted request transaction.
      function void take_request(logic [OP_W-1:0] op, logic [REQ_TDATA_W-1:0] data);
         screen_reply_t reply;
         logic [IDX_W-1:0] idx;
         idx = data[CHAR_W +: IDX_W];
         reply.cell_value = '0;
         if (op == OP_PUT) apply_put(data[CHAR_W-1:0]);
         else if (idx < CELLS) reply.cell_value = screen[idx];
         reply.pos = POS_W'(cursor());
         pending_replies.push_back(reply);
      endfunction

      // Called for every accepted response transaction.
      function void check_response(logic [RSP_TDATA_W-1:0] data);
         screen_reply_t want;
         if (pending_replies.size() == 0) begin
            $display("%0t: response with nothing expected: %h", $time, data);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         if (data[CELL_W-1:0] !== want.cell_value) begin
            $display("%0t: cell_data mismatch: expected %h, actual %h",
                     $time, want.cell_value, data[CELL_W-1:0]);
            failures++;
         end
         if (data[CELL_W +: POS_W] !== want.pos) begin
            $display("%0t: cursor_pos mismatch: expected %0d, actual %0d",
                     $time, want.pos, data[CELL_W +: POS_W]);
            failures++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser;   // operation
   logic [REQ_TDATA_W-1:0] req_tdata;   // char_code, read_index, zero fill
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // cell_data, cursor_pos, zero fill
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [COLOR_W-1:0]     csr_wdata;

   screen_mirror mirror = new();
   bit           no_idle = 0;
   bit           hold_off_req = 0;
   int           items_sent = 0;

   text_console_cell_writer #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H),
      .TAB_STOP     (TAB_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: covers the clearing pass and every put scrolling under worst stalls.
   initial begin
      #150_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Transaction monitors on both channels.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) mirror.take_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) mirror.check_response(rsp_tdata);
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // Response side: random ready stretches, plus one long hold-off on request.
   initial begin
      int run_len;
      int gap;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         run_len = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until accepted, then maybe idle.
   task automatic send_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W - CHAR_W - IDX_W){1'b0}}, idx, ch};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put_char(logic [CHAR_W-1:0] ch);
      send_item(OP_PUT, ch, IDX_W'($urandom));
   endtask

   task automatic read_cell(logic [IDX_W-1:0] idx);
      send_item(OP_READ, CHAR_W'($urandom), idx);
   endtask

   // Stop offering and wait until every response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.outstanding() != 0) @(posedge clock);
   endtask

   // Write both color registers on consecutive cycles, with no request in flight.
   task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
      csr_we    <= 1'b1;
      csr_addr  <= REG_FG;
      csr_wdata <= fg;
      @(posedge clock);
      mirror.set_color(REG_FG, fg);
      csr_addr  <= REG_BG;
      csr_wdata <= bg;
      @(posedge clock);
      mirror.set_color(REG_BG, bg);
      csr_we <= 1'b0;
   endtask

   // Mostly printable text, sometimes any byte.
   function automatic logic [CHAR_W-1:0] text_byte();
      if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom);
      return CHAR_W'($urandom_range(8'h20, 8'h7E));
   endfunction

   // Random traffic built from short typing sequences, reads and noise.
   task automatic run_phase(int n_items);
      int stop_at;
      int kind;
      int len;
      int unsigned pos;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // A line of text, usually short, sometimes long enough to wrap.
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20) : $urandom_range(21, 100);
            repeat (len) put_char(text_byte());
            case ($urandom_range(0, 4))
               0, 1, 2: put_char(CH_LF);
               3: begin
                  put_char(CH_CR);
                  put_char(CH_LF);
               end
               default: ;
            endcase
         end else if (kind < 50) begin
            // A run of tabs, long enough at times to cross the line end.
            repeat ($urandom_range(1, 11)) begin
               if ($urandom_range(0, 1)) put_char(text_byte());
               put_char(CH_TAB);
            end
         end else if (kind < 62) begin
            // Typing then erasing, which may back up to column zero, where a backspace is written as a byte.
            repeat ($urandom_range(0, 5)) put_char(text_byte());
            repeat ($urandom_range(1, 8)) put_char(CH_BACKSPACE);
         end else if (kind < 85) begin
            // Reads: the cell before the cursor, anywhere, or past the screen.
            repeat ($urandom_range(1, 6)) begin
               pos = mirror.cursor();
               case ($urandom_range(0, 9))
                  0, 1, 2: read_cell(IDX_W'((pos == 0) ? 0 : pos - 1));
                  3, 4: read_cell(IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1)));
                  default: read_cell(IDX_W'($urandom_range(0, CELLS - 1)));
               endcase
            end
         end else begin
            // Noise: any byte, control codes included.
            repeat ($urandom_range(1, 4)) put_char(CHAR_W'($urandom));
         end
      end
   endtask

   // Stimulus.
   initial begin
      req_tvalid = 1'b0;
      req_tuser  = OP_PUT;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = REG_FG;
      csr_wdata  = '0;
      reset      = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_colors(4'hA, 4'h5);

      // Directed: reset contents, field extremes and every cursor control.
      read_cell(IDX_W'(0));
      read_cell(IDX_W'(CELLS - 1));
      read_cell(IDX_W'(CELLS));
      read_cell(IDX_W'((1 << IDX_W) - 1));
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CH_BACKSPACE);
      put_char(8'h80);
      put_char(CH_CR);
      put_char(CH_BACKSPACE);
      put_char(CH_TAB);
      put_char(CH_TAB);
      put_char(CH_LF);
      put_char(CH_BACKSPACE);
      read_cell(IDX_W'(0));
      read_cell(IDX_W'(1));
      read_cell(IDX_W'(2));
      read_cell(IDX_W'(SCREEN_W));
      read_cell(IDX_W'(SCREEN_W + 1));
      wait_drained();

      // Color extremes and then random colors, one setting per phase.
      set_colors(4'h0, 4'h0);
      run_phase(PHASE_ITEMS);
      wait_drained();

      // Long receiver hold-off while requests keep coming.
      set_colors(4'hF, 4'hF);
      hold_off_req = 1;
      run_phase(PHASE_ITEMS);
      wait_drained();

      // No idling on either side.
      set_colors(4'hF, 4'h0);
      no_idle = 1;
      run_phase(PHASE_ITEMS);
      wait_drained();
      no_idle = 0;

      set_colors(4'h0, 4'hF);
      run_phase(PHASE_ITEMS);
      wait_drained();

      set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
      run_phase(PHASE_ITEMS);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mirror.failures == 0 && mirror.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/tccw_pkg.sv
design/tccw_datapath.sv
design/tccw_ctrl.sv
design/text_console_cell_writer.sv
design/tccw_checker.sv
sim/testbench.sv
